[design/rci_pkg.sv]
package rci_pkg;

    // field and datapath widths
    localparam int CW     = 24;          // coordinate field
    localparam int FW     = CW + 1;      // origin minus centre
    localparam int RW     = 16;          // radius register
    localparam int DISTW  = 20;          // Q12.8 distance
    localparam int AW     = 48;          // a = D.D
    localparam int HW     = 50;          // h = F.D, signed
    localparam int HMW    = 48;          // |h|
    localparam int CDW    = 51;          // c = F.F - r*r, signed
    localparam int CMW    = 49;          // |c|
    localparam int PW     = 96;          // h*h and a*|c|
    localparam int QW     = 98;          // discriminant, even for digit pairs
    localparam int SW     = QW / 2;      // square root width
    localparam int REMW   = SW + 3;      // square root remainder
    localparam int NW     = 51;          // root numerator, signed
    localparam int DNW    = NW - 1 + 8;  // numerator scaled to Q.8
    localparam int TW     = DISTW + 1;   // quotient saturated at 2^20
    localparam int DREMW  = AW + DISTW;  // divider remainder
    localparam int SQ_LAT = SW;          // square root pipeline depth
    localparam int DV_LAT = DISTW + 1;   // divider pipeline depth

    localparam int PAW    = 4;
    localparam int PDW    = 32;

    localparam logic [RW-1:0]    RADIUS_RST   = RW'(5120);
    localparam logic [DISTW-1:0] MIN_DIST_RST = DISTW'(13);
    localparam logic [DISTW-1:0] MAX_DIST_RST = DISTW'(1024000);

    typedef enum logic [1:0] {
        REG_RADIUS   = 2'd0,
        REG_MIN_DIST = 2'd1,
        REG_MAX_DIST = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_z;
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_z;
        logic                 target_live;
    } t_rci_in;

    typedef struct packed {
        logic             hit;
        logic [DISTW-1:0] distance;
    } t_rci_out;

    // travels alongside the square root
    typedef struct packed {
        logic signed [HW-1:0] h;
        logic [AW-1:0]        a;
        logic                 miss;
    } t_sq_side;

    // travels alongside the dividers
    typedef struct packed {
        logic miss;
        logic near_neg;
        logic far_neg;
    } t_dv_side;

endpackage

[design/rci_if.sv]
interface rci_in_if;
    import rci_pkg::*;
    logic    valid;
    logic    ready;
    t_rci_in payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rci_out_if;
    import rci_pkg::*;
    logic     valid;
    logic     ready;
    t_rci_out payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/rci_sqrt.sv]
module rci_sqrt (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [rci_pkg::QW-1:0]    i_rad,
    output logic [rci_pkg::SW-1:0]    o_root
);
    import rci_pkg::*;

    // one result bit per stage, restoring digit-by-digit method
    logic [QW-1:0]   r_rad  [0:SW-1];
    logic [REMW-1:0] r_rem  [0:SW-1];
    logic [SW-1:0]   r_root [0:SW-1];

    genvar k;
    for (k = 0; k < SW; k++) begin : g_step
        logic [QW-1:0]   w_rad;
        logic [REMW-1:0] w_rem_in;
        logic [SW-1:0]   w_root_in;
        logic [REMW-1:0] w_rem;
        logic [REMW-1:0] w_trial;

        if (k == 0) begin : g_first
            assign w_rad     = i_rad;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rad     = r_rad[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
        end

        assign w_rem   = {w_rem_in[REMW-3:0], w_rad[QW-1 -: 2]};
        assign w_trial = {1'b0, w_root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k] <= w_rad << 2;
                if (w_rem >= w_trial) begin
                    r_rem[k]  <= w_rem - w_trial;
                    r_root[k] <= {w_root_in[SW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_rem;
                    r_root[k] <= {w_root_in[SW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[SW-1];

endmodule

[design/rci_div.sv]
module rci_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [rci_pkg::DNW-1:0]   i_num,
    input  logic [rci_pkg::AW-1:0]    i_den,
    output logic [rci_pkg::TW-1:0]    o_quot
);
    import rci_pkg::*;

    // quotient saturates at 2^20; below that one bit per stage
    logic [DREMW-1:0] r_rem [0:DISTW];
    logic [AW-1:0]    r_den [0:DISTW];
    logic [DISTW-1:0] r_q   [0:DISTW];
    logic             r_ovf [0:DISTW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= DREMW'(i_num) >= {i_den, {DISTW{1'b0}}};
            r_rem[0] <= DREMW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
        end
    end

    genvar k;
    for (k = 1; k <= DISTW; k++) begin : g_step
        logic [DREMW-1:0] w_trial;
        assign w_trial = DREMW'(r_den[k-1]) << (DISTW - k);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[k] <= r_ovf[k-1];
                r_den[k] <= r_den[k-1];
                if (r_rem[k-1] >= w_trial) begin
                    r_rem[k] <= r_rem[k-1] - w_trial;
                    r_q[k]   <= r_q[k-1] | (DISTW'(1) << (DISTW - k));
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_q[k]   <= r_q[k-1];
                end
            end
        end
    end

    assign o_quot = r_ovf[DISTW] ? {1'b1, {DISTW{1'b0}}} : {1'b0, r_q[DISTW]};

endmodule

[design/ray_circle_intersection_unit.sv]
// Ray-circle intersection in the x/z plane. Each item carries a ray origin,
// an unnormalised direction, a circle centre (signed Q15.8) and a live flag;
// each item gives exactly one result: hit and the ray parameter t (Q12.8,
// zero on a miss). The near root is taken, or the far root when the near one
// is negative or below min_distance; a hit needs min_distance <= t <=
// max_distance. The datapath is a 78-stage pipeline: six stages of products
// and sums, 49 square-root stages (one root bit each), one numerator stage,
// 21 divider stages (near and far in parallel, quotient saturated at 2^20)
// and the output register. An item may enter every cycle while the output is
// not held; results come out in order. When the output is held the whole pipe halts.
// Registers sit on an APB port: radius at 0x0, min_distance at 0x4,
// max_distance at 0x8; write them only while the pipe is empty.
module ray_circle_intersection_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [rci_pkg::PAW-1:0]  paddr,
    input  logic [rci_pkg::PDW-1:0]  pwdata,
    output logic [rci_pkg::PDW-1:0]  prdata,
    output logic                     pready,
    rci_in_if.sink                   i_req,
    rci_out_if.source                o_rsp
);
    import rci_pkg::*;

    // ---------------- configuration ----------------
    logic [RW-1:0]    r_radius;
    logic [DISTW-1:0] r_min_dist;
    logic [DISTW-1:0] r_max_dist;
    t_reg_idx         w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_RST;
            r_min_dist <= MIN_DIST_RST;
            r_max_dist <= MAX_DIST_RST;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_RADIUS:   r_radius   <= pwdata[RW-1:0];
                REG_MIN_DIST: r_min_dist <= pwdata[DISTW-1:0];
                REG_MAX_DIST: r_max_dist <= pwdata[DISTW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RADIUS:   prdata = PDW'(r_radius);
            REG_MIN_DIST: prdata = PDW'(r_min_dist);
            REG_MAX_DIST: prdata = PDW'(r_max_dist);
            default:      prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // every stage moves together; only a held result stops the pipe
    logic     w_en;
    logic     r_ovalid;
    t_rci_out r_out;

    assign w_en          = !r_ovalid || o_rsp.ready;
    assign i_req.ready   = w_en;
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_out;

    // ---------------- stage 1: F = O - C ----------------
    logic                 r_v1, r_live1;
    logic signed [FW-1:0] r_fx, r_fz;
    logic signed [CW-1:0] r_dx, r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_en) r_v1 <= i_req.valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fx    <= FW'(i_req.payload.origin_x) - FW'(i_req.payload.center_x);
            r_fz    <= FW'(i_req.payload.origin_z) - FW'(i_req.payload.center_z);
            r_dx    <= i_req.payload.dir_x;
            r_dz    <= i_req.payload.dir_z;
            r_live1 <= i_req.payload.target_live;
        end
    end

    // ---------------- stage 2: products ----------------
    logic                     r_v2, r_live2;
    logic signed [2*CW-1:0]   r_dxx, r_dzz;
    logic signed [FW+CW-1:0]  r_fdx, r_fdz;
    logic signed [2*FW-1:0]   r_fxx, r_fzz;
    logic [2*RW-1:0]          r_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_en) r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dxx   <= r_dx * r_dx;
            r_dzz   <= r_dz * r_dz;
            r_fdx   <= r_fx * (FW+CW)'(r_dx);
            r_fdz   <= r_fz * (FW+CW)'(r_dz);
            r_fxx   <= r_fx * r_fx;
            r_fzz   <= r_fz * r_fz;
            r_rr    <= r_radius * r_radius;
            r_live2 <= r_live1;
        end
    end

    // ---------------- stage 3: a, h, c ----------------
    logic                  r_v3, r_miss3;
    logic [AW-1:0]         r_a3;
    logic signed [HW-1:0]  r_h3;
    logic signed [CDW-1:0] r_c3;
    logic [AW-1:0]         w_a;

    assign w_a = $unsigned(r_dxx) + $unsigned(r_dzz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (w_en) r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a3    <= w_a;
            r_h3    <= HW'(r_fdx) + HW'(r_fdz);
            r_c3    <= CDW'(r_fxx) + CDW'(r_fzz) - CDW'(r_rr);
            r_miss3 <= !r_live2 || (w_a == '0);
        end
    end

    // ---------------- stage 4: partial products of h*h and a*|c| ----------------
    logic [HW-1:0]  w_hneg;
    logic [CDW-1:0] w_cneg;
    logic [HMW-1:0] w_habs;
    logic [CMW-1:0] w_cabs;

    assign w_hneg = HW'(0) - r_h3;
    assign w_cneg = CDW'(0) - r_c3;
    assign w_habs = r_h3[HW-1] ? w_hneg[HMW-1:0] : r_h3[HMW-1:0];
    assign w_cabs = r_c3[CDW-1] ? w_cneg[CMW-1:0] : r_c3[CMW-1:0];

    logic                 r_v4, r_miss4, r_cpos4;
    logic [AW-1:0]        r_a4;
    logic signed [HW-1:0] r_h4;
    logic [47:0]          r_hh00, r_hh01, r_hh11;
    logic [48:0]          r_ac00, r_ac10;
    logic [47:0]          r_ac01, r_ac11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (w_en) r_v4 <= r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hh00  <= w_habs[23:0]  * w_habs[23:0];
            r_hh01  <= w_habs[23:0]  * w_habs[47:24];
            r_hh11  <= w_habs[47:24] * w_habs[47:24];
            r_ac00  <= r_a3[23:0]  * w_cabs[24:0];
            r_ac01  <= r_a3[23:0]  * w_cabs[48:25];
            r_ac10  <= r_a3[47:24] * w_cabs[24:0];
            r_ac11  <= r_a3[47:24] * w_cabs[48:25];
            r_cpos4 <= !r_c3[CDW-1] && (r_c3 != '0);
            r_a4    <= r_a3;
            r_h4    <= r_h3;
            r_miss4 <= r_miss3;
        end
    end

    // ---------------- stage 5: h*h and a*|c| ----------------
    logic                 r_v5, r_miss5, r_cpos5;
    logic [AW-1:0]        r_a5;
    logic signed [HW-1:0] r_h5;
    logic [PW-1:0]        r_hh, r_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else if (w_en) r_v5 <= r_v4;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hh    <= (PW'(r_hh11) << 48) + (PW'(r_hh01) << 25) + PW'(r_hh00);
            r_ac    <= (PW'(r_ac11) << 49) + (PW'(r_ac10) << 24)
                     + (PW'(r_ac01) << 25) + PW'(r_ac00);
            r_cpos5 <= r_cpos4;
            r_a5    <= r_a4;
            r_h5    <= r_h4;
            r_miss5 <= r_miss4;
        end
    end

    // ---------------- stage 6: discriminant ----------------
    logic          r_v6;
    logic [QW-1:0] r_q6;
    t_sq_side      r_side6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else if (w_en) r_v6 <= r_v5;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q6         <= r_cpos5 ? QW'(r_hh) - QW'(r_ac) : QW'(r_hh) + QW'(r_ac);
            r_side6.h    <= r_h5;
            r_side6.a    <= r_a5;
            r_side6.miss <= r_miss5 || (r_cpos5 && (r_ac > r_hh));
        end
    end

    // ---------------- square root, with h, a and flags alongside ----------------
    logic [SW-1:0] w_s;
    t_sq_side      r_sq_side [0:SQ_LAT-1];
    logic          r_sq_v    [0:SQ_LAT-1];

    rci_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_q6),
        .o_root (w_s)
    );

    genvar g;
    for (g = 0; g < SQ_LAT; g++) begin : g_sq_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_v[g] <= 1'b0;
            else if (w_en) r_sq_v[g] <= (g == 0) ? r_v6 : r_sq_v[(g == 0) ? 0 : g-1];
        end
        always_ff @(posedge i_clk) begin
            if (w_en) r_sq_side[g] <= (g == 0) ? r_side6 : r_sq_side[(g == 0) ? 0 : g-1];
        end
    end

    // ---------------- stage 7: root numerators ----------------
    t_sq_side             w_sq;
    logic signed [NW-1:0] w_nn, w_nf;

    assign w_sq = r_sq_side[SQ_LAT-1];
    assign w_nn = NW'(0) - NW'(w_sq.h) - NW'(w_s);
    assign w_nf = NW'(0) - NW'(w_sq.h) + NW'(w_s);

    logic           r_v7;
    logic [DNW-1:0] r_num_n, r_num_f;
    logic [AW-1:0]  r_a7;
    t_dv_side       r_side7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v7 <= 1'b0;
        else if (w_en) r_v7 <= r_sq_v[SQ_LAT-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num_n          <= w_nn[NW-1] ? '0 : {w_nn[NW-2:0], 8'b0};
            r_num_f          <= w_nf[NW-1] ? '0 : {w_nf[NW-2:0], 8'b0};
            r_a7             <= w_sq.a;
            r_side7.miss     <= w_sq.miss;
            r_side7.near_neg <= w_nn[NW-1];
            r_side7.far_neg  <= w_nf[NW-1];
        end
    end

    // ---------------- dividers: t = n*256 / a, near and far ----------------
    logic [TW-1:0] w_tn, w_tf;
    t_dv_side      r_dv_side [0:DV_LAT-1];
    logic          r_dv_v    [0:DV_LAT-1];

    rci_div u_div_near (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_num_n),
        .i_den  (r_a7),
        .o_quot (w_tn)
    );

    rci_div u_div_far (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_num_f),
        .i_den  (r_a7),
        .o_quot (w_tf)
    );

    for (g = 0; g < DV_LAT; g++) begin : g_dv_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_v[g] <= 1'b0;
            else if (w_en) r_dv_v[g] <= (g == 0) ? r_v7 : r_dv_v[(g == 0) ? 0 : g-1];
        end
        always_ff @(posedge i_clk) begin
            if (w_en) r_dv_side[g] <= (g == 0) ? r_side7 : r_dv_side[(g == 0) ? 0 : g-1];
        end
    end

    // ---------------- output: root choice and window ----------------
    // a saturated quotient (2^20) is above any max_distance, so it misses
    t_dv_side      w_dv;
    logic          w_near_ok, w_ok, w_hit;
    logic [TW-1:0] w_t, w_min, w_max;

    assign w_dv      = r_dv_side[DV_LAT-1];
    assign w_min     = TW'(r_min_dist);
    assign w_max     = TW'(r_max_dist);
    assign w_near_ok = !w_dv.near_neg && (w_tn >= w_min);
    assign w_t       = w_near_ok ? w_tn : w_tf;
    assign w_ok      = w_near_ok ? (w_tn <= w_max)
                                 : (!w_dv.far_neg && (w_tf >= w_min) && (w_tf <= w_max));
    assign w_hit     = !w_dv.miss && w_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_en) r_ovalid <= r_dv_v[DV_LAT-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.hit      <= w_hit;
            r_out.distance <= w_hit ? w_t[DISTW-1:0] : '0;
        end
    end

endmodule

[verif/rci_checker.sv]
`timescale 1ns / 100ps

module rci_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [rci_pkg::PAW-1:0]  paddr,
    input  logic [rci_pkg::PDW-1:0]  pwdata,
    rci_in_if                        req,
    rci_out_if                       rsp,
    output int                       o_fails,
    output int                       o_pending
);
    import rci_pkg::*;

    logic [RW-1:0]    radius_q;
    logic [DISTW-1:0] min_dist_q;
    logic [DISTW-1:0] max_dist_q;
    t_rci_out         hits_due[$];

    function automatic t_rci_out predict_hit(t_rci_in it);
        t_rci_out             res;
        longint               fx, fz, dx, dz, h, c, s, n;
        longint unsigned      a, t, root, cand;
        logic signed [131:0]  hw, aw, cw, q, cc;
        bit                   ok;
        res = '0;
        fx  = longint'(it.origin_x) - longint'(it.center_x);
        fz  = longint'(it.origin_z) - longint'(it.center_z);
        dx  = longint'(it.dir_x);
        dz  = longint'(it.dir_z);
        a   = dx * dx + dz * dz;
        if (!it.target_live || a == 0) return res;
        h  = fx * dx + fz * dz;
        c  = fx * fx + fz * fz - longint'(radius_q) * longint'(radius_q);
        hw = h;
        cw = c;
        aw = $signed({68'b0, a});
        q  = hw * hw - aw * cw;
        if (q < 0) return res;
        root = 0;
        for (int b = 50; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            cc   = $signed({68'b0, cand});
            if (cc * cc <= q) root = cand;
        end
        s  = longint'(root);
        // near root first, far root when near is negative or too close
        n  = -h - s;
        ok = (n >= 0);
        if (ok) t = (longint'(n) << 8) / a;
        if (!ok || t < min_dist_q) begin
            n  = -h + s;
            ok = (n >= 0);
            if (ok) t = (longint'(n) << 8) / a;
        end
        if (!ok || t < min_dist_q || t > max_dist_q) return res;
        res.hit      = 1'b1;
        res.distance = t[DISTW-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rci_out want;
        if (!i_rst_n) begin
            radius_q   <= RADIUS_RST;
            min_dist_q <= MIN_DIST_RST;
            max_dist_q <= MAX_DIST_RST;
            o_fails    <= 0;
            o_pending  <= 0;
            hits_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_RADIUS:   radius_q   <= pwdata[RW-1:0];
                    REG_MIN_DIST: min_dist_q <= pwdata[DISTW-1:0];
                    REG_MAX_DIST: max_dist_q <= pwdata[DISTW-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                hits_due.push_back(predict_hit(req.payload));
            if (rsp.valid && rsp.ready) begin
                if (hits_due.size() == 0) begin
                    if (o_fails < 10)
                        $display("unexpected result hit=%0d distance=%0d",
                                 rsp.payload.hit, rsp.payload.distance);
                    o_fails <= o_fails + 1;
                end else begin
                    want = hits_due.pop_front();
                    if (want != rsp.payload) begin
                        if (o_fails < 10)
                            $display({"mismatch: expected hit=%0d distance=%0d,",
                                      " got hit=%0d distance=%0d"},
                                     want.hit, want.distance,
                                     rsp.payload.hit, rsp.payload.distance);
                        o_fails <= o_fails + 1;
                    end
                end
            end
            o_pending <= hits_due.size();
        end
    end

endmodule

[verif/tb_ray_circle_intersection_unit.sv]
`timescale 1ns / 100ps

module tb_ray_circle_intersection_unit;
    import rci_pkg::*;

    localparam int N_PHASES   = 7;
    localparam int RAND_ITEMS = 250;   // per phase
    localparam int CALM_ITEMS = 150;   // no idling at the tail
    localparam int DRAIN_WAIT = 90;    // pipe is 78 deep
    localparam int LONG_HOLD  = 300;
    localparam int WD_LIMIT   = 3000;

    logic             i_clk;
    logic             i_rst_n;
    logic             psel, penable, pwrite;
    logic [PAW-1:0]   paddr;
    logic [PDW-1:0]   pwdata;
    logic [PDW-1:0]   prdata;
    logic             pready;
    int               fails;
    int               pending;
    int               idle_cycles;
    bit               calm;        // no idling on either side
    bit               hold_req;    // asks the receiver for a long hold-off

    rci_in_if  ray_ch ();
    rci_out_if hit_ch ();

    ray_circle_intersection_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (ray_ch),
        .o_rsp   (hit_ch)
    );

    rci_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .req       (ray_ch),
        .rsp       (hit_ch),
        .o_fails   (fails),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog expired");
            $display("ray_circle_intersection_unit verification failed");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                hit_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD - 1;
                hit_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 9);
                hit_ch.ready <= 1'b0;
            end else begin
                hit_ch.ready <= 1'b1;
            end
        end
    end

    // APB write: setup, access, then idle
    task automatic reg_write(t_reg_idx r, logic [PDW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // upper bus bits are junk; the block must ignore them
    task automatic set_window(logic [RW-1:0] rad, logic [DISTW-1:0] lo,
                              logic [DISTW-1:0] hi);
        reg_write(REG_RADIUS,   {16'($urandom), rad});
        reg_write(REG_MIN_DIST, {12'($urandom), lo});
        reg_write(REG_MAX_DIST, {12'($urandom), hi});
    endtask

    function automatic logic signed [CW-1:0] rnd_coord();
        return CW'($urandom);
    endfunction

    function automatic logic signed [CW-1:0] edge_coord();
        case ($urandom_range(0, 4))
            0: return -24'sd8388608;
            1: return 24'sd8388607;
            2: return 24'sd0;
            3: return 24'sd1;
            default: return -24'sd1;
        endcase
    endfunction

    // mostly rays aimed near a circle, the rest raw noise and extremes
    function automatic t_rci_in random_ray();
        t_rci_in r;
        int      ox, oz, offx, offz, sh, sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            ox   = int'($urandom_range(0, 131072)) - 65536;
            oz   = int'($urandom_range(0, 131072)) - 65536;
            offx = int'($urandom_range(0, 32768)) - 16384;
            offz = int'($urandom_range(0, 32768)) - 16384;
            sh   = $urandom_range(0, 4);
            r.origin_x = CW'(ox);
            r.origin_z = CW'(oz);
            r.center_x = CW'(ox + offx);
            r.center_z = CW'(oz + offz);
            r.dir_x    = CW'(((offx >>> 2) <<< sh) + int'($urandom_range(0, 2047)) - 1024);
            r.dir_z    = CW'(((offz >>> 2) <<< sh) + int'($urandom_range(0, 2047)) - 1024);
            if ($urandom_range(0, 4) == 0) begin
                r.dir_x = -r.dir_x;   // pointing away
                r.dir_z = -r.dir_z;
            end
        end else if (sel < 85) begin
            r.origin_x = rnd_coord(); r.origin_z = rnd_coord();
            r.dir_x    = rnd_coord(); r.dir_z    = rnd_coord();
            r.center_x = rnd_coord(); r.center_z = rnd_coord();
        end else begin
            r.origin_x = edge_coord(); r.origin_z = edge_coord();
            r.dir_x    = edge_coord(); r.dir_z    = edge_coord();
            r.center_x = edge_coord(); r.center_z = edge_coord();
        end
        r.target_live = ($urandom_range(0, 9) != 0);
        return r;
    endfunction

    function automatic t_rci_in directed_ray(int k);
        t_rci_in r;
        r = '0;
        r.target_live = 1'b1;
        case (k)
            0: ;                                          // zero direction
            1: begin                                      // dead target in line
                r.center_x = 24'sd25600; r.dir_x = 24'sd256; r.target_live = 1'b0;
            end
            2: begin r.center_x = 24'sd25600; r.dir_x = 24'sd256; end   // plain hit
            3: begin r.center_x = -24'sd25600; r.dir_x = 24'sd256; end  // circle behind
            4: r.dir_x = 24'sd256;                        // origin inside, far root
            5: begin                                      // misses sideways
                r.center_x = 24'sd25600; r.center_z = 24'sd12800; r.dir_x = 24'sd256;
            end
            6: begin                                      // grazing
                r.center_x = 24'sd25600; r.center_z = 24'sd5120; r.dir_x = 24'sd256;
            end
            7: begin
                r.origin_x = 24'sd8388607; r.origin_z = 24'sd8388607;
                r.dir_x    = 24'sd8388607; r.dir_z    = 24'sd8388607;
                r.center_x = 24'sd8388607; r.center_z = 24'sd8388607;
            end
            8: begin
                r.origin_x = -24'sd8388608; r.origin_z = -24'sd8388608;
                r.dir_x    = -24'sd8388608; r.dir_z    = -24'sd8388608;
                r.center_x = -24'sd8388608; r.center_z = -24'sd8388608;
            end
            9: begin
                r.origin_x = 24'sd8388607;  r.origin_z = 24'sd8388607;
                r.center_x = -24'sd8388608; r.center_z = -24'sd8388608;
                r.dir_x    = -24'sd8388608; r.dir_z    = -24'sd8388608;
            end
            10: begin
                r.origin_x = -24'sd8388608; r.origin_z = -24'sd8388608;
                r.center_x = 24'sd8388607;  r.center_z = 24'sd8388607;
                r.dir_x    = 24'sd8388607;  r.dir_z    = 24'sd8388607;
            end
            11: begin r.center_x = 24'sd256000; r.dir_x = 24'sd1; end   // t far too big
            12: begin
                r.center_x = 24'sd25600; r.center_z = 24'sd25600;
                r.dir_x = 24'sd8388607;  r.dir_z = 24'sd8388607;
            end
            13: begin r.center_z = -24'sd25600; r.dir_z = -24'sd256; end
            14: begin
                r.origin_x = 24'sd3000; r.origin_z = 24'sd3000;
                r.dir_x = -24'sd1; r.dir_z = -24'sd1;
            end
            15: begin                                     // dead target with zero dir
                r.target_live = 1'b0;
            end
            default: r = random_ray();
        endcase
        return r;
    endfunction

    // sender
    initial begin
        t_rci_in item;
        int      n_total, n_sent;
        logic [RW-1:0]    rads [N_PHASES];
        logic [DISTW-1:0] lows [N_PHASES];
        logic [DISTW-1:0] highs[N_PHASES];

        rads  = '{16'd5120, 16'd0,  16'd65535, 16'd5120,     16'd0, 16'd2560, 16'd12000};
        lows  = '{20'd13,   20'd0,  20'd0,     20'd1048575, 20'd0, 20'd300,  20'd13};
        highs = '{20'd1024000, 20'd1048575, 20'd1048575, 20'd1048575,
                  20'd20480, 20'd100, 20'd50000};
        rads[4]  = RW'($urandom);
        lows[4]  = DISTW'($urandom_range(0, 20480));

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        ray_ch.valid   = 1'b0;
        ray_ch.payload = '0;
        hit_ch.ready   = 1'b0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        idle_cycles    = 0;
        n_total        = 20 + N_PHASES * RAND_ITEMS;
        n_sent         = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            set_window(rads[p], lows[p], highs[p]);
            for (int k = 0; k < (p == 0 ? 20 + RAND_ITEMS : RAND_ITEMS); k++) begin
                item = (p == 0 && k < 20) ? directed_ray(k) : random_ray();
                if (n_sent >= n_total - CALM_ITEMS) calm = 1'b1;
                // block fills while the receiver holds off
                if (p == 1 && k == 10) hold_req = 1'b1;
                if (p == 2 && k == 100) begin
                    ray_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    ray_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge i_clk);
                end
                ray_ch.valid   <= 1'b1;
                ray_ch.payload <= item;
                do @(posedge i_clk); while (!ray_ch.ready);
                n_sent++;
            end
            ray_ch.valid <= 1'b0;
            @(posedge i_clk);
            wait_drained();
        end

        if (fails == 0 && pending == 0)
            $display("ray_circle_intersection_unit verification clean");
        else
            $display("ray_circle_intersection_unit verification failed");
        $finish;
    end

endmodule

[sim.f]
design/rci_pkg.sv
design/rci_if.sv
design/rci_sqrt.sv
design/rci_div.sv
design/ray_circle_intersection_unit.sv
verif/rci_checker.sv
verif/tb_ray_circle_intersection_unit.sv
